/* rtl/core/bsal_pkg.sv */
// Package: transaction types, codes and constants of the bar-synced audio looper.
`timescale 1ns / 1ps

package bsal_pkg;

    localparam int DEFAULT_MAX_FRAMES = 262144;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 19;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIX           = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LENGTH = 1'd1;

    localparam logic [16:0] MIX_ONE             = 17'd65536;
    localparam logic [16:0] MIX_RESET           = 17'd65536;
    localparam logic [18:0] TARGET_LENGTH_RESET = 19'd88200;

    localparam int BAR_SHIFT = 18;
    localparam int BAR_W     = 33 - BAR_SHIFT;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_RECORD  = 3'd1;
    localparam logic [2:0] CMD_OVERDUB = 3'd2;
    localparam logic [2:0] CMD_PLAY    = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_ARMED     = 3'd1;
    localparam logic [2:0] MODE_RECORDING = 3'd2;
    localparam logic [2:0] MODE_PLAYING   = 3'd3;
    localparam logic [2:0] MODE_OVERDUB   = 3'd4;

    typedef struct packed {
        logic signed [15:0] live_sample;
        logic [31:0]        beat_position;
        logic [2:0]         command;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic [2:0]         mode;
        logic               loop_present;
    } out_item_t;

endpackage

/* rtl/core/bsal_loop_mem.sv */
// Loop sample store: one write port, two registered read ports.
`timescale 1ns / 1ps

module bsal_loop_mem
    import bsal_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_FRAMES,
    parameter int AW    = $clog2(DEFAULT_MAX_FRAMES)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [15:0]   wdata,
    input  logic [AW-1:0]        raddr_a,
    input  logic [AW-1:0]        raddr_b,
    output logic signed [15:0]   rdata_a,
    output logic signed [15:0]   rdata_b
);

    logic signed [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/bsal_rem_unit.sv */
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module bsal_rem_unit
    import bsal_pkg::*;
#(
    parameter int W = $clog2(DEFAULT_MAX_FRAMES + 1)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dq_reg, dq_next;
    logic [W-1:0]  dv_reg, dv_next;
    logic [W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[W-1]};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dv_next   = dv_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            dq_next   = dividend;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dv_reg})
            begin
                rem_next = W'(trial - {1'b0, dv_reg});
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            dq_next  = {dq_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dv_reg  <= dv_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/bar_synced_audio_looper_core.sv */
// Bar-synced audio looper: command control, loop store access and output mix.
// A transaction passes store read, overdub read-modify-write and mix multiply,
// with a remainder pass (one length bit per cycle) before the mix when a stale
// play position lies past the loop length. The mix loads the output register
// when no output is pending or it is taken; then the next input is accepted.
// Reset clears control state only; store entries past the fill count read as zero.
`timescale 1ns / 1ps

module bar_synced_audio_looper_core
    import bsal_pkg::*;
#(
    parameter int MAX_FRAMES = DEFAULT_MAX_FRAMES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int LW = $clog2(MAX_FRAMES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MIX  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    mode_reg, mode_next;
    logic          pend_reg, pend_next;
    logic [32:0]   start_beat_reg, start_beat_next;
    logic [LW-1:0] wp_reg, wp_next;
    logic [AW-1:0] pp_reg, pp_next;
    logic [LW-1:0] len_reg, len_next;
    logic          flag_reg, flag_next;
    logic [2:0]    last_cmd_reg, last_cmd_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic          a_ok_reg, a_ok_next;
    logic          b_ok_reg, b_ok_next;
    logic          out_valid_reg, out_valid_next;
    logic [16:0]   mix_reg;
    logic [18:0]   tlen_reg;

    in_item_t           item_reg;
    logic signed [33:0] prod_live_reg;
    logic signed [15:0] loop_smp_reg, loop_smp_next;
    out_item_t          out_data_reg, out_data_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [15:0] mem_wdata;
    logic signed [15:0] rdata_a, rdata_b;

    logic          rem_start;
    logic [LW-1:0] rem_dividend;
    logic          rem_done;
    logic [LW-1:0] rem_result;

    logic [16:0]        mix_m;
    logic signed [17:0] mix_m_s;
    logic signed [17:0] mix_om_s;
    logic signed [33:0] prod_live;
    logic signed [33:0] prod_loop;
    logic signed [34:0] acc;
    logic signed [18:0] acc_sh;
    logic signed [15:0] mixed;

    bsal_loop_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (wp_reg[AW-1:0]),
        .raddr_b (pp_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bsal_rem_unit #(
        .W (LW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (len_reg),
        .done      (rem_done),
        .remainder (rem_result)
    );

    // mix datapath
    assign mix_m     = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    assign mix_m_s   = signed'({1'b0, mix_m});
    assign mix_om_s  = signed'({1'b0, 17'(MIX_ONE - mix_m)});
    assign prod_live = item_reg.live_sample * mix_om_s;
    assign prod_loop = loop_smp_reg * mix_m_s;
    assign acc       = 35'(prod_live_reg) + 35'(prod_loop) + 35'sd32768;
    assign acc_sh    = acc[34:16];

    always_comb
    begin
        if (acc_sh > 19'sd32767)
        begin
            mixed = 16'sh7FFF;
        end
        else if (acc_sh < -19'sd32768)
        begin
            mixed = 16'sh8000;
        end
        else
        begin
            mixed = acc_sh[15:0];
        end
    end

    always_comb
    begin
        logic [2:0]         md;
        logic               pd;
        logic [32:0]        sb;
        logic [LW-1:0]      wp;
        logic [AW-1:0]      pp;
        logic [LW-1:0]      ln;
        logic               fl;
        logic [LW-1:0]      fc;
        logic [31:0]        tl32;
        logic [31:0]        tl_clamp;
        logic signed [15:0] a_val;
        logic signed [15:0] b_val;
        logic signed [16:0] od_sum;
        logic signed [15:0] od_val;
        logic               od_wr;
        logic [LW-1:0]      succ;
        logic [LW-1:0]      wrap1;

        md = mode_reg;
        pd = pend_reg;
        sb = start_beat_reg;
        wp = wp_reg;
        pp = pp_reg;
        ln = len_reg;
        fl = flag_reg;
        fc = fill_reg;
        tl32     = 32'(tlen_reg);
        tl_clamp = tl32;
        a_val  = a_ok_reg ? rdata_a : 16'sd0;
        b_val  = b_ok_reg ? rdata_b : 16'sd0;
        od_sum = 17'(a_val) + 17'(item_reg.live_sample);
        od_val = '0;
        od_wr  = 1'b0;
        succ   = LW'(pp_reg) + LW'(1);
        wrap1  = succ - len_reg;

        state_next      = state_reg;
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        start_beat_next = start_beat_reg;
        wp_next         = wp_reg;
        pp_next         = pp_reg;
        len_next        = len_reg;
        flag_next       = flag_reg;
        last_cmd_next   = last_cmd_reg;
        fill_next       = fill_reg;
        a_ok_next       = a_ok_reg;
        b_ok_next       = b_ok_reg;
        loop_smp_next   = loop_smp_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg[AW-1:0];
        mem_wdata       = item_reg.live_sample;
        rem_start       = 1'b0;
        rem_dividend    = succ;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command != last_cmd_reg)
                    begin
                        case (in_data.command)
                            CMD_RECORD, CMD_OVERDUB:
                            begin
                                pd = (in_data.command == CMD_OVERDUB);
                                md = MODE_ARMED;
                                sb = {BAR_W'({1'b0, in_data.beat_position[31:BAR_SHIFT]})
                                      + BAR_W'(1), {BAR_SHIFT{1'b0}}};
                            end
                            CMD_PLAY:
                            begin
                                md = fl ? MODE_PLAYING : MODE_IDLE;
                                pp = '0;
                            end
                            CMD_STOP:
                            begin
                                md = MODE_IDLE;
                            end
                            default:
                            begin
                                md = md;
                            end
                        endcase
                    end

                    if (md == MODE_ARMED && {1'b0, in_data.beat_position} >= sb)
                    begin
                        wp = '0;
                        if (!pd)
                        begin
                            if (tl32 == 32'd0)
                            begin
                                tl_clamp = 32'd1;
                            end
                            else if (tl32 > 32'(MAX_FRAMES))
                            begin
                                tl_clamp = 32'(MAX_FRAMES);
                            end
                            ln = LW'(tl_clamp);
                            fl = 1'b0;
                            fc = '0;
                            md = MODE_RECORDING;
                        end
                        else
                        begin
                            md = MODE_OVERDUB;
                        end
                    end

                    if (md == MODE_RECORDING)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wp[AW-1:0];
                        mem_wdata = in_data.live_sample;
                        if (wp == fc)
                        begin
                            fc = fc + LW'(1);
                        end
                        wp = wp + LW'(1);
                        if (wp >= ln)
                        begin
                            fl = 1'b1;
                            pp = '0;
                            md = MODE_PLAYING;
                        end
                    end

                    mode_next       = md;
                    pend_next       = pd;
                    start_beat_next = sb;
                    wp_next         = wp;
                    pp_next         = pp;
                    len_next        = ln;
                    flag_next       = fl;
                    fill_next       = fc;
                    last_cmd_next   = in_data.command;
                    state_next      = S_READ;
                end
            end

            S_READ:
            begin
                a_ok_next  = wp_reg < fill_reg;
                b_ok_next  = LW'(pp_reg) < fill_reg;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                state_next    = S_MIX;
                loop_smp_next = '0;
                if (mode_reg == MODE_OVERDUB && len_reg != '0)
                begin
                    if (od_sum > 17'sd32767)
                    begin
                        od_val = 16'sh7FFF;
                    end
                    else if (od_sum < -17'sd32768)
                    begin
                        od_val = 16'sh8000;
                    end
                    else
                    begin
                        od_val = od_sum[15:0];
                    end
                    od_wr     = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg[AW-1:0];
                    mem_wdata = od_val;
                    if (wp_reg == fill_reg)
                    begin
                        fill_next = fill_reg + LW'(1);
                    end
                    if (wp_reg + LW'(1) == len_reg)
                    begin
                        wp_next = '0;
                    end
                    else
                    begin
                        wp_next = wp_reg + LW'(1);
                    end
                end
                if ((mode_reg == MODE_PLAYING || mode_reg == MODE_OVERDUB)
                    && len_reg != '0)
                begin
                    // an overdub write to the entry being played is forwarded to the playback sample
                    if (od_wr && LW'(pp_reg) == wp_reg)
                    begin
                        loop_smp_next = od_val;
                    end
                    else
                    begin
                        loop_smp_next = b_val;
                    end
                    if (succ < len_reg)
                    begin
                        pp_next = succ[AW-1:0];
                    end
                    else if (wrap1 < len_reg)
                    begin
                        pp_next = wrap1[AW-1:0];
                    end
                    else
                    begin
                        rem_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (rem_done)
                begin
                    pp_next    = rem_result[AW-1:0];
                    state_next = S_MIX;
                end
            end

            S_MIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.out_sample   = mixed;
                    out_data_next.mode         = mode_reg;
                    out_data_next.loop_present = flag_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_IDLE;
            pend_reg       <= 1'b0;
            start_beat_reg <= '0;
            wp_reg         <= '0;
            pp_reg         <= '0;
            len_reg        <= '0;
            flag_reg       <= 1'b0;
            last_cmd_reg   <= CMD_NONE;
            fill_reg       <= '0;
            a_ok_reg       <= 1'b0;
            b_ok_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            mix_reg        <= MIX_RESET;
            tlen_reg       <= TARGET_LENGTH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            start_beat_reg <= start_beat_next;
            wp_reg         <= wp_next;
            pp_reg         <= pp_next;
            len_reg        <= len_next;
            flag_reg       <= flag_next;
            last_cmd_reg   <= last_cmd_next;
            fill_reg       <= fill_next;
            a_ok_reg       <= a_ok_next;
            b_ok_reg       <= b_ok_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MIX:
                    begin
                        mix_reg <= cfg_data[16:0];
                    end
                    CFG_TARGET_LENGTH:
                    begin
                        tlen_reg <= cfg_data[18:0];
                    end
                    default:
                    begin
                        mix_reg <= mix_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_READ)
        begin
            prod_live_reg <= prod_live;
        end
        loop_smp_reg <= loop_smp_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/tb_top.sv */
// Testbench for the bar-synced audio looper core: directed table plus random command streams.
`timescale 1ns / 1ps

module tb_top;
    import bsal_pkg::*;

    localparam int LOOP_FRAMES    = DEFAULT_MAX_FRAMES;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 50;
    localparam int STEADY_PHASE   = 5;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        in_item_t               item;
        out_item_t              want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bit        steady = 1'b0;
    int        errors = 0;
    int        idle_cycles = 0;
    out_item_t pending_outputs[$];
    out_item_t oldest;
    plan_row_t directed[$];

    // looper state as seen by the predictor
    shortint     loop_mem[LOOP_FRAMES];
    int unsigned mem_gen[LOOP_FRAMES];
    int unsigned clear_gen = 1;
    logic [2:0]  lp_mode = MODE_IDLE;
    logic        lp_pending_overdub = 1'b0;
    logic [32:0] lp_bar_start = '0;
    int unsigned lp_write_pos = 0;
    int unsigned lp_play_pos = 0;
    int unsigned lp_length = 0;
    logic        lp_present = 1'b0;
    logic [2:0]  lp_last_cmd = CMD_NONE;
    int unsigned mix_setting = MIX_RESET;
    int unsigned length_setting = TARGET_LENGTH_RESET;

    bar_synced_audio_looper_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    // entries not written since the last record start read as zero
    function automatic int stored_frame(input int unsigned idx);
        return (mem_gen[idx] == clear_gen) ? int'(loop_mem[idx]) : 0;
    endfunction

    function automatic void store_frame(input int unsigned idx, input int value);
        loop_mem[idx] = shortint'(value);
        mem_gen[idx]  = clear_gen;
    endfunction

    function automatic out_item_t next_output(input in_item_t it);
        int          live;
        logic [32:0] beat;
        logic [2:0]  cmd;
        int          loop_smp;
        int unsigned len;
        int unsigned pos;
        int unsigned m;
        longint      acc;
        out_item_t   o;
        live     = int'($signed(it.live_sample));
        beat     = {1'b0, it.beat_position};
        cmd      = it.command;
        loop_smp = 0;

        if (cmd != lp_last_cmd) begin
            if (cmd == CMD_RECORD || cmd == CMD_OVERDUB) begin
                lp_pending_overdub = (cmd == CMD_OVERDUB);
                lp_mode            = MODE_ARMED;
                lp_bar_start       = ((beat >> BAR_SHIFT) + 33'd1) << BAR_SHIFT;
            end else if (cmd == CMD_PLAY) begin
                lp_mode     = lp_present ? MODE_PLAYING : MODE_IDLE;
                lp_play_pos = 0;
            end else if (cmd == CMD_STOP) begin
                lp_mode = MODE_IDLE;
            end
            lp_last_cmd = cmd;
        end

        if (lp_mode == MODE_ARMED && beat >= lp_bar_start) begin
            if (!lp_pending_overdub) begin
                len = length_setting;
                if (len < 1)
                    len = 1;
                if (len > LOOP_FRAMES)
                    len = LOOP_FRAMES;
                clear_gen++;
                lp_write_pos = 0;
                lp_length    = len;
                lp_present   = 1'b0;
                lp_mode      = MODE_RECORDING;
            end else begin
                lp_write_pos = 0;
                lp_mode      = MODE_OVERDUB;
            end
        end

        if (lp_mode == MODE_RECORDING) begin
            if (lp_write_pos < lp_length)
                store_frame(lp_write_pos, live);
            lp_write_pos++;
            if (lp_write_pos >= lp_length) begin
                lp_present  = 1'b1;
                lp_play_pos = 0;
                lp_mode     = MODE_PLAYING;
            end
        end else if (lp_mode == MODE_OVERDUB && lp_length > 0) begin
            pos = lp_write_pos % lp_length;
            store_frame(pos, clamp16(longint'(stored_frame(pos)) + longint'(live)));
            lp_write_pos = (pos + 1) % lp_length;
        end

        if ((lp_mode == MODE_PLAYING || lp_mode == MODE_OVERDUB) && lp_length > 0) begin
            if (lp_play_pos < LOOP_FRAMES)
                loop_smp = stored_frame(lp_play_pos);
            lp_play_pos = (lp_play_pos + 1) % lp_length;
        end

        m   = (mix_setting > MIX_ONE) ? MIX_ONE : mix_setting;
        acc = longint'(live) * longint'(MIX_ONE - m) + longint'(loop_smp) * longint'(m)
              + 64'sd32768;
        o.out_sample   = 16'(clamp16(acc >>> 16));
        o.mode         = lp_mode;
        o.loop_present = lp_present;
        return o;
    endfunction

    function automatic plan_row_t checked_row(input logic [15:0] live, input logic [31:0] beat,
                                              input logic [2:0] cmd, input logic [15:0] smp,
                                              input logic [2:0] md, input logic present);
        plan_row_t r;
        r.kind                   = ROW_CHECKED;
        r.reg_index              = '0;
        r.reg_value              = '0;
        r.item.live_sample       = live;
        r.item.beat_position     = beat;
        r.item.command           = cmd;
        r.want.out_sample        = smp;
        r.want.mode              = md;
        r.want.loop_present      = present;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic [15:0] live, input logic [31:0] beat,
                                           input logic [2:0] cmd);
        plan_row_t r;
        r      = checked_row(live, beat, cmd, 16'h0, MODE_IDLE, 1'b0);
        r.kind = ROW_ITEM;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r           = item_row(16'h0, 32'h0, CMD_NONE);
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = next_output(it);
        pending_outputs.push_back(typed ? want : predicted);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_MIX)
            mix_setting = value[16:0];
        else
            length_setting = value;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected transaction, actual %p", $time, out_data);
                errors++;
            end else begin
                oldest = pending_outputs.pop_front();
                if (out_data.out_sample !== oldest.out_sample) begin
                    $display("%0t: out_sample expected %0d actual %0d", $time,
                             $signed(oldest.out_sample), $signed(out_data.out_sample));
                    errors++;
                end
                if (out_data.mode !== oldest.mode) begin
                    $display("%0t: mode expected %0d actual %0d", $time,
                             oldest.mode, out_data.mode);
                    errors++;
                end
                if (out_data.loop_present !== oldest.loop_present) begin
                    $display("%0t: loop_present expected %0d actual %0d", $time,
                             oldest.loop_present, out_data.loop_present);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL bar_synced_audio_looper_core");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int          hold;
        int          pick;
        int unsigned short_len;
        logic [2:0]  cmd;
        logic [31:0] song;
        logic [15:0] live;
        logic [18:0] value;
        in_item_t    it;

        hold = 0;
        cmd  = CMD_NONE;
        song = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            checked_row(16'h7FFF, 32'h0,        CMD_NONE,   16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h8000, 32'hFFFFFFFF, 3'd5,       16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h0001, 32'h10,       CMD_PLAY,   16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h1234, 32'h20,       3'd6,       16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h1234, 32'h30,       3'd7,       16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h4321, 32'h40,       CMD_STOP,   16'h0, MODE_IDLE,  1'b0),
            checked_row(16'h0100, 32'h3FFFF,    CMD_RECORD, 16'h0, MODE_ARMED, 1'b0),
            checked_row(16'h0A0A, 32'h40000,    CMD_RECORD, 16'h0, MODE_RECORDING, 1'b0),
            item_row(16'h0B0B, 32'h50000, CMD_RECORD),
            checked_row(16'h0C0C, 32'h60000,    CMD_STOP,   16'h0, MODE_IDLE,  1'b0),
            // a beat exactly on a bar start waits for the following bar
            checked_row(16'h0D0D, 32'h80000,    CMD_OVERDUB, 16'h0, MODE_ARMED, 1'b0),
            item_row(16'h7FFF, 32'hC0000, CMD_OVERDUB),
            item_row(16'h7FFF, 32'hD0000, CMD_OVERDUB),
            item_row(16'h0000, 32'hE0000, CMD_STOP),
            // boundary past the 32-bit beat range: stays armed
            checked_row(16'h0000, 32'hFFFFFFF0, CMD_RECORD, 16'h0, MODE_ARMED, 1'b0),
            checked_row(16'h0000, 32'hFFFFFFFF, CMD_RECORD, 16'h0, MODE_ARMED, 1'b0),
            cfg_row(CFG_MIX, 19'd0),
            cfg_row(CFG_TARGET_LENGTH, 19'd0),
            checked_row(16'h7FFF, 32'h0,        CMD_NONE,   16'h7FFF, MODE_ARMED, 1'b0),
            item_row(16'h8000, 32'h0,     CMD_RECORD),
            item_row(16'h8000, 32'h40000, CMD_RECORD),
            cfg_row(CFG_MIX, 19'h7FFFF),
            item_row(16'h7FFF, 32'h50000, CMD_PLAY),
            item_row(16'h8000, 32'h60000, CMD_OVERDUB),
            item_row(16'h8000, 32'h80000, CMD_OVERDUB),
            item_row(16'h8000, 32'h90000, CMD_OVERDUB),
            cfg_row(CFG_TARGET_LENGTH, 19'h7FFFF),
            item_row(16'h7FFF, 32'h90000, CMD_RECORD),
            item_row(16'h0001, 32'hC0000, CMD_RECORD),
            item_row(16'h0002, 32'hD0000, CMD_PLAY),
            cfg_row(CFG_TARGET_LENGTH, 19'd262144),
            item_row(16'hFFFF, 32'hE0000, CMD_STOP)
        };

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].reg_index, directed[i].reg_value);
            else
                send_item(directed[i].item, directed[i].kind == ROW_CHECKED, directed[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(4))
                0: value = 19'd0;
                1: value = 19'd65536;
                2: value = 19'($urandom_range(0, 65536));
                3: value = 19'($urandom_range(65537, 131071));
                default: value = 19'($urandom);
            endcase
            write_register(CFG_MIX, value);
            case (phase)
                2: value = 19'd262144;
                7: value = 19'h7FFFF;
                10: value = 19'd0;
                default: value = ($urandom_range(9) == 0) ? 19'($urandom)
                                                           : 19'($urandom_range(1, 40));
            endcase
            write_register(CFG_TARGET_LENGTH, value);
            short_len = (length_setting > 50) ? 50 : length_setting;
            steady = (phase == STEADY_PHASE);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (hold == 0) begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                        cmd = CMD_RECORD;
                    else if (pick < 48)
                        cmd = CMD_OVERDUB;
                    else if (pick < 63)
                        cmd = CMD_PLAY;
                    else if (pick < 75)
                        cmd = CMD_STOP;
                    else if (pick < 85)
                        cmd = CMD_NONE;
                    else
                        cmd = 3'($urandom_range(5, 7));
                    hold = $urandom_range(1, 12);
                    if (cmd == CMD_RECORD && $urandom_range(1) == 1)
                        hold = short_len + $urandom_range(4, 10);
                end
                hold--;

                case ($urandom_range(9))
                    6: song = song + 32'h40000;
                    7: song = song + 32'($urandom_range(0, 16'hFFFF));
                    8: song = $urandom;
                    9: song = 32'hFFFC0000 + 32'($urandom_range(0, 32'h3FFFF));
                    default: song = song + 32'h10000;
                endcase

                case ($urandom_range(9))
                    0: live = 16'h7FFF;
                    1: live = 16'h8000;
                    default: live = 16'($urandom);
                endcase

                it.live_sample   = live;
                it.beat_position = song;
                it.command       = cmd;
                send_item(it, 1'b0, '0);
            end
        end

        steady = 1'b0;
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS bar_synced_audio_looper_core");
        else
            $display("FAIL bar_synced_audio_looper_core");
        $finish;
    end

endmodule

/* files.f */
rtl/core/bsal_pkg.sv
rtl/core/bsal_loop_mem.sv
rtl/core/bsal_rem_unit.sv
rtl/core/bar_synced_audio_looper_core.sv
tb/tb_top.sv
